[hw/rtl/aob_pkg.sv]
// Package for the alpha-over blend: channel width, fixed-point helpers and
// the structs passed between the pipeline sections.
// Depends on nothing; every other RTL file imports it.
package aob_pkg;

   // Internal channel precision and the width of each field on the ports.
   localparam int CHANNEL_BITS = 8;
   localparam int FIELD_BITS   = 8;
   localparam int CW           = CHANNEL_BITS;
   // Width of a product of two channels.
   localparam int PW           = 2 * CW;
   // Width of a weighted colour sum plus its rounding term.
   localparam int DIVW         = 2 * CW + 1;
   // Three colour lanes: red, green, blue.
   localparam int LANES        = 3;

   localparam int REQ_WIDTH    = 8 * FIELD_BITS;
   localparam int RSP_WIDTH    = 4 * FIELD_BITS;

   localparam logic [CW-1:0]         FULL_SCALE    = '1;
   localparam logic [FIELD_BITS-1:0] OPACITY_RESET = '1;
   localparam logic [PW+1:0]         ROUND_HALF    = (PW+2)'(2 ** (CW - 1));

   typedef logic [CW-1:0] chan_type;
   typedef logic [LANES-1:0][CW-1:0] colour_type;

   // One input beat after saturation to full scale.
   typedef struct packed {
      colour_type src;
      chan_type   src_alpha;
      colour_type dst;
      chan_type   dst_alpha;
   } pixel_type;

   // Leaves the weight section: both weights and the two colours.
   typedef struct packed {
      logic       valid;
      colour_type src;
      colour_type dst;
      chan_type   ws;
      chan_type   wd;
   } weight_type;

   // Leaves the mix section: rounded dividends, output alpha, bypass colour.
   typedef struct packed {
      logic                           valid;
      logic [LANES-1:0][DIVW-1:0]     dividend;
      chan_type                       oa;
      colour_type                     src;
   } mix_type;

   // One finished result beat.
   typedef struct packed {
      logic       valid;
      colour_type colour;
      chan_type   alpha;
   } result_type;

   // Clamp an 8-bit port field to full scale.
   function automatic chan_type sat_field(input logic [FIELD_BITS-1:0] v);
      if (int'(v) > int'(FULL_SCALE)) begin
         return FULL_SCALE;
      end
      return CW'(v);
   endfunction

   // round(x / FULL_SCALE) for a product of two channels, without a divider:
   // division by 2^CW - 1 is done by the add-shift identity.
   function automatic chan_type div_fs(input logic [PW-1:0] x);
      logic [PW+1:0] t;
      logic [PW+1:0] r;
      t = (PW+2)'(x) + ROUND_HALF;
      r = (t + (t >> CW)) >> CW;
      if (r > (PW+2)'(FULL_SCALE)) begin
         return FULL_SCALE;
      end
      return r[CW-1:0];
   endfunction

endpackage

[hw/rtl/alpha_over_blend_with_opacity.sv]
// Top level of the alpha-over blend with global opacity.
// Depends on aob_pkg, aob_weight, aob_mix, aob_div and aob_skid.
//
// Blends a non-premultiplied source pixel over a destination pixel, scaled by
// the opacity register, and returns the non-premultiplied result. One pixel
// is taken and one result given in every clock cycle while the pipeline is not
// frozen; a result passes four weight stages, two mix stages, one divider stage
// per quotient bit and the output register. A stalled result channel freezes
// the pipeline once the skid entry has caught a beat in flight, so req_tready
// falls only while that entry is occupied. Opacity resets to full scale and
// should be written only while the pipeline is empty.
module alpha_over_blend_with_opacity import aob_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // Request beats.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // src_red, src_green, src_blue, src_alpha, dst_red, dst_green, dst_blue,
   // dst_alpha, eight bits each from bit 0 up.
   input  logic [REQ_WIDTH-1:0]  req_tdata,
   // Result beats.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // out_red, out_green, out_blue, out_alpha, eight bits each from bit 0 up.
   output logic [RSP_WIDTH-1:0]  rsp_tdata,
   // Opacity register write.
   input  logic                  csr_wen,
   input  logic [FIELD_BITS-1:0] csr_wdata
);

   logic [FIELD_BITS-1:0] opacity_ff, opacity_in;
   pixel_type             pixel;
   weight_type            weight;
   mix_type               mix;
   result_type            result;
   logic                  advance;
   colour_type            out_colour;
   chan_type              out_alpha;

   // Opacity register.
   assign opacity_in = csr_wen ? csr_wdata : opacity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         opacity_ff <= OPACITY_RESET;
      end else begin
         opacity_ff <= opacity_in;
      end
   end

   // Unpack and clamp the request beat.
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         pixel.src[l] = sat_field(req_tdata[FIELD_BITS*l +: FIELD_BITS]);
         pixel.dst[l] = sat_field(req_tdata[FIELD_BITS*(l+4) +: FIELD_BITS]);
      end
      pixel.src_alpha = sat_field(req_tdata[FIELD_BITS*3 +: FIELD_BITS]);
      pixel.dst_alpha = sat_field(req_tdata[FIELD_BITS*7 +: FIELD_BITS]);
   end

   assign req_tready = advance;

   aob_weight u_weight (
      .clock      (clock),
      .reset      (reset),
      .en         (advance),
      .in_valid   (req_tvalid),
      .opacity    (sat_field(opacity_ff)),
      .in_pixel   (pixel),
      .out_weight (weight)
   );

   aob_mix u_mix (
      .clock     (clock),
      .reset     (reset),
      .en        (advance),
      .in_weight (weight),
      .out_mix   (mix)
   );

   aob_div u_div (
      .clock      (clock),
      .reset      (reset),
      .en         (advance),
      .in_mix     (mix),
      .out_result (result)
   );

   aob_skid u_skid (
      .clock      (clock),
      .reset      (reset),
      .in_result  (result),
      .advance    (advance),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_colour (out_colour),
      .out_alpha  (out_alpha)
   );

   // Pack the result beat, each channel cut or widened to the field width.
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         rsp_tdata[FIELD_BITS*l +: FIELD_BITS] = FIELD_BITS'(out_colour[l]);
      end
      rsp_tdata[FIELD_BITS*3 +: FIELD_BITS] = FIELD_BITS'(out_alpha);
   end

endmodule

[hw/rtl/aob_weight.sv]
// Weight section of the blend pipeline: four register stages that form the
// source weight and the destination weight. Depends on aob_pkg.
module aob_weight import aob_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       en,
   input  logic       in_valid,
   input  chan_type   opacity,
   input  pixel_type  in_pixel,
   output weight_type out_weight
);

   logic [3:0]    valid_ff, valid_in;

   // Stage 1: source alpha times opacity.
   pixel_type     pix1_ff, pix1_in;
   logic [PW-1:0] prod_s_ff, prod_s_in;
   // Stage 2: source weight.
   colour_type    src2_ff, src2_in, dst2_ff, dst2_in;
   chan_type      dst_alpha2_ff, dst_alpha2_in, ws2_ff, ws2_in;
   // Stage 3: destination alpha times the remaining coverage.
   colour_type    src3_ff, src3_in, dst3_ff, dst3_in;
   chan_type      ws3_ff, ws3_in;
   logic [PW-1:0] prod_d_ff, prod_d_in;
   // Stage 4: destination weight.
   colour_type    src4_ff, src4_in, dst4_ff, dst4_in;
   chan_type      ws4_ff, ws4_in, wd4_ff, wd4_in;

   // Next values of every stage; the whole section moves on en.
   always_comb begin
      valid_in      = {valid_ff[2:0], in_valid};

      pix1_in       = in_pixel;
      prod_s_in     = PW'(in_pixel.src_alpha) * PW'(opacity);

      src2_in       = pix1_ff.src;
      dst2_in       = pix1_ff.dst;
      dst_alpha2_in = pix1_ff.dst_alpha;
      ws2_in        = div_fs(prod_s_ff);

      src3_in       = src2_ff;
      dst3_in       = dst2_ff;
      ws3_in        = ws2_ff;
      prod_d_in     = PW'(dst_alpha2_ff) * PW'(FULL_SCALE - ws2_ff);

      src4_in       = src3_ff;
      dst4_in       = dst3_ff;
      ws4_in        = ws3_ff;
      wd4_in        = div_fs(prod_d_ff);
   end

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (en) begin
         pix1_ff       <= pix1_in;
         prod_s_ff     <= prod_s_in;
         src2_ff       <= src2_in;
         dst2_ff       <= dst2_in;
         dst_alpha2_ff <= dst_alpha2_in;
         ws2_ff        <= ws2_in;
         src3_ff       <= src3_in;
         dst3_ff       <= dst3_in;
         ws3_ff        <= ws3_in;
         prod_d_ff     <= prod_d_in;
         src4_ff       <= src4_in;
         dst4_ff       <= dst4_in;
         ws4_ff        <= ws4_in;
         wd4_ff        <= wd4_in;
      end
   end

   assign out_weight.valid = valid_ff[3];
   assign out_weight.src   = src4_ff;
   assign out_weight.dst   = dst4_ff;
   assign out_weight.ws    = ws4_ff;
   assign out_weight.wd    = wd4_ff;

endmodule

[hw/rtl/aob_mix.sv]
// Mix section of the blend pipeline: two register stages that form the
// output alpha and the rounded weighted colour sums. Depends on aob_pkg.
module aob_mix import aob_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       en,
   input  weight_type in_weight,
   output mix_type    out_mix
);

   logic [1:0]                 valid_ff, valid_in;

   // Stage 5: the two products per lane and the saturated alpha sum.
   logic [LANES-1:0][PW-1:0]   prod_a_ff, prod_a_in, prod_b_ff, prod_b_in;
   chan_type                   oa5_ff, oa5_in;
   colour_type                 src5_ff, src5_in;
   // Stage 6: weighted sum plus half the divisor for round-half-up.
   logic [LANES-1:0][DIVW-1:0] dividend_ff, dividend_in;
   chan_type                   oa6_ff, oa6_in;
   colour_type                 src6_ff, src6_in;

   logic [CW:0]                alpha_sum;

   always_comb begin
      valid_in  = {valid_ff[0], in_weight.valid};
      alpha_sum = {1'b0, in_weight.ws} + {1'b0, in_weight.wd};
      oa5_in    = alpha_sum[CW] ? FULL_SCALE : alpha_sum[CW-1:0];
      src5_in   = in_weight.src;
      for (int l = 0; l < LANES; l++) begin
         prod_a_in[l] = PW'(in_weight.ws) * PW'(in_weight.src[l]);
         prod_b_in[l] = PW'(in_weight.wd) * PW'(in_weight.dst[l]);
      end

      oa6_in  = oa5_ff;
      src6_in = src5_ff;
      for (int l = 0; l < LANES; l++) begin
         dividend_in[l] = DIVW'(prod_a_ff[l]) + DIVW'(prod_b_ff[l])
                        + DIVW'(oa5_ff >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_a_ff   <= prod_a_in;
         prod_b_ff   <= prod_b_in;
         oa5_ff      <= oa5_in;
         src5_ff     <= src5_in;
         dividend_ff <= dividend_in;
         oa6_ff      <= oa6_in;
         src6_ff     <= src6_in;
      end
   end

   assign out_mix.valid    = valid_ff[1];
   assign out_mix.dividend = dividend_ff;
   assign out_mix.oa       = oa6_ff;
   assign out_mix.src      = src6_ff;

endmodule

[hw/rtl/aob_div.sv]
// Pipelined restoring divider for the three colour lanes: one quotient bit
// per stage, CHANNEL_BITS stages, sharing the output alpha as divisor.
// Depends on aob_pkg.
module aob_div import aob_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       en,
   input  mix_type    in_mix,
   output result_type out_result
);

   // Stage registers, one entry per quotient bit, most significant first.
   logic [CW-1:0]              valid_ff;
   logic [LANES-1:0][DIVW-1:0] rem_ff [CW];
   colour_type                 quo_ff [CW];
   chan_type                   oa_ff  [CW];
   colour_type                 src_ff [CW];

   for (genvar k = 0; k < CW; k++) begin : g_stage
      localparam int BIT = CW - 1 - k;

      logic                       prev_valid;
      logic [LANES-1:0][DIVW-1:0] prev_rem;
      colour_type                 prev_quo;
      chan_type                   prev_oa;
      colour_type                 prev_src;
      logic [DIVW-1:0]            shifted;
      logic [LANES-1:0][DIVW-1:0] rem_in;
      colour_type                 quo_in;

      if (k == 0) begin : g_first
         assign prev_valid = in_mix.valid;
         assign prev_rem   = in_mix.dividend;
         assign prev_quo   = '0;
         assign prev_oa    = in_mix.oa;
         assign prev_src   = in_mix.src;
      end else begin : g_next
         assign prev_valid = valid_ff[k-1];
         assign prev_rem   = rem_ff[k-1];
         assign prev_quo   = quo_ff[k-1];
         assign prev_oa    = oa_ff[k-1];
         assign prev_src   = src_ff[k-1];
      end

      // Trial subtraction of the divisor at this bit's weight.
      always_comb begin
         shifted = DIVW'(prev_oa) << BIT;
         rem_in  = prev_rem;
         quo_in  = prev_quo;
         for (int l = 0; l < LANES; l++) begin
            if (prev_rem[l] >= shifted) begin
               rem_in[l]      = prev_rem[l] - shifted;
               quo_in[l][BIT] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= prev_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            quo_ff[k] <= quo_in;
            oa_ff[k]  <= prev_oa;
            src_ff[k] <= prev_src;
         end
      end
   end

   // A fully transparent result keeps the source colour.
   always_comb begin
      out_result.valid = valid_ff[CW-1];
      out_result.alpha = oa_ff[CW-1];
      for (int l = 0; l < LANES; l++) begin
         out_result.colour[l] = (oa_ff[CW-1] == '0) ? src_ff[CW-1][l]
                                                    : quo_ff[CW-1][l];
      end
   end

endmodule

[hw/rtl/aob_skid.sv]
// Output register with a skid entry: holds finished beats while the result
// channel stalls and tells the pipeline when to advance. Depends on aob_pkg.
module aob_skid import aob_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  result_type in_result,
   output logic       advance,
   output logic       out_valid,
   input  logic       out_ready,
   output colour_type out_colour,
   output chan_type   out_alpha
);

   logic       out_v_ff, out_v_in, skid_v_ff, skid_v_in;
   result_type out_ff, out_in, skid_ff, skid_in;
   logic       out_take;

   // The pipeline moves whenever the skid entry is free.
   assign advance  = !skid_v_ff;
   assign out_take = out_v_ff && out_ready;

   always_comb begin
      out_v_in  = out_v_ff;
      skid_v_in = skid_v_ff;
      out_in    = out_ff;
      skid_in   = skid_ff;
      if (skid_v_ff) begin
         // Pipeline is frozen; drain the skid entry once the output is taken.
         if (out_take) begin
            out_in    = skid_ff;
            skid_v_in = 1'b0;
         end
      end else if (in_result.valid) begin
         if (!out_v_ff || out_take) begin
            out_in   = in_result;
            out_v_in = 1'b1;
         end else begin
            skid_in   = in_result;
            skid_v_in = 1'b1;
         end
      end else if (out_take) begin
         out_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign out_valid  = out_v_ff;
   assign out_colour = out_ff.colour;
   assign out_alpha  = out_ff.alpha;

endmodule
